// File: rtl/act_pkg.sv
// shared types, constants and tables for the activation unit
package act_pkg;

    typedef enum logic [1:0] {
        ACT_RELU    = 2'd0,
        ACT_ELU     = 2'd1,
        ACT_SIGMOID = 2'd2,
        ACT_TANH    = 2'd3
    } act_kind_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_KIND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd1;

    localparam logic [11:0] ALPHA_RESET = 12'd1024;

    localparam int EXP_STAGES = 16;
    localparam int DIV_STAGES = 12;
    localparam int LATENCY    = 1 + EXP_STAGES + 3 + DIV_STAGES + 1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] grad_in;
    } act_in_t;

    typedef struct packed {
        logic signed [15:0] result_value;
        logic               saturated;
    } act_out_t;

    typedef struct packed {
        act_kind_t          kind;
        logic               mode;
        logic               neg;
        logic               pos;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] g;
        logic [11:0]        alpha;
    } act_side_t;

    typedef struct packed {
        act_kind_t          kind;
        logic               mode;
        logic               neg;
        logic               pos;
        logic signed [15:0] g;
        logic signed [15:0] fwd;
        logic signed [47:0] prod;
    } act_post_t;

    // e^-(2^(b-11)) in Q0.16
    function automatic logic [15:0] exp_factor(input int unsigned b);
        logic [15:0] f;
        case (b)
            0:       f = 16'd65504;
            1:       f = 16'd65472;
            2:       f = 16'd65408;
            3:       f = 16'd65280;
            4:       f = 16'd65026;
            5:       f = 16'd64520;
            6:       f = 16'd63520;
            7:       f = 16'd61565;
            8:       f = 16'd57835;
            9:       f = 16'd51039;
            10:      f = 16'd39750;
            11:      f = 16'd24109;
            12:      f = 16'd8869;
            13:      f = 16'd1200;
            14:      f = 16'd22;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage

// File: rtl/act_exp.sv
// pipelined e^-t, one factor multiply per stage
module act_exp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  act_pkg::act_side_t in_side,
    input  logic [15:0]       in_arg,
    input  logic              in_zero,
    output logic              out_valid,
    output act_pkg::act_side_t out_side,
    output logic [16:0]       out_e
);
    import act_pkg::*;

    logic [EXP_STAGES-1:0] valid_reg;
    act_side_t             side_reg [EXP_STAGES];
    logic [15:0]           arg_reg  [EXP_STAGES];
    logic [16:0]           acc_reg  [EXP_STAGES];

    for (genvar k = 0; k < EXP_STAGES; k++) begin : g_stage
        logic        v_in;
        act_side_t   s_in;
        logic [15:0] a_in;
        logic [16:0] acc_in;
        logic [32:0] prod;
        logic [16:0] acc_next;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign s_in   = in_side;
            assign a_in   = in_arg;
            assign acc_in = in_zero ? 17'd0 : 17'd65536;
        end
        else begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign s_in   = side_reg[k-1];
            assign a_in   = arg_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        assign prod     = 33'(acc_in) * 33'(exp_factor(k)) + 33'd32768;
        assign acc_next = a_in[k] ? prod[32:16] : acc_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= s_in;
            arg_reg[k]  <= a_in;
            acc_reg[k]  <= acc_next;
        end
    end

    assign out_valid = valid_reg[EXP_STAGES-1];
    assign out_side  = side_reg[EXP_STAGES-1];
    assign out_e     = acc_reg[EXP_STAGES-1];

endmodule

// File: rtl/act_div.sv
// pipelined restoring divider, one quotient bit per stage
module act_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  act_pkg::act_post_t in_post,
    input  logic [27:0]        in_num,
    input  logic [17:0]        in_den,
    output logic               out_valid,
    output act_pkg::act_post_t out_post,
    output logic [11:0]        out_quo
);
    import act_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    act_post_t             post_reg [DIV_STAGES];
    logic [27:0]           rem_reg  [DIV_STAGES];
    logic [17:0]           den_reg  [DIV_STAGES];
    logic [11:0]           quo_reg  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int BIT = DIV_STAGES - 1 - k;
        logic        v_in;
        act_post_t   p_in;
        logic [27:0] rem_in;
        logic [17:0] den_in;
        logic [11:0] quo_in;
        logic [29:0] dsh;
        logic        ge;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign p_in   = in_post;
            assign rem_in = in_num;
            assign den_in = in_den;
            assign quo_in = 12'd0;
        end
        else begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign p_in   = post_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign dsh = 30'(den_in) << BIT;
        assign ge  = ({2'b00, rem_in} >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            post_reg[k] <= p_in;
            den_reg[k]  <= den_in;
            rem_reg[k]  <= ge ? 28'({2'b00, rem_in} - dsh) : rem_in;
            quo_reg[k]  <= quo_in | (12'(ge) << BIT);
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_post  = post_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];

endmodule

// File: rtl/activation_unit_core.sv
// activation unit top level: relu, elu, sigmoid, tanh forward and backward
//
//  channel   signals                          direction
//  request   start, busy, request             in
//  result    done, result                     out
//  config    cfg_write, cfg_index, cfg_data   in
//
// one request per cycle, every request gives one result
// path: capture, the 16-stage exponential, p1, p2, p3, the 12-stage divider, output
// busy is never raised; the receiver cannot stall and none is needed
// reset clears the valid chain and loads relu with alpha 0.5
module activation_unit_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  act_pkg::act_in_t                  request,
    output logic                              done,
    output act_pkg::act_out_t                 result,
    input  logic                              cfg_write,
    input  logic [act_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [act_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import act_pkg::*;

    // configuration
    act_kind_t   kind_reg, kind_next;
    logic [11:0] alpha_reg, alpha_next;

    always_comb
    begin
        kind_next  = kind_reg;
        alpha_next = alpha_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_KIND:  kind_next  = act_kind_t'(cfg_data[1:0]);
                CFG_ALPHA: alpha_next = cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= ACT_RELU;
            alpha_reg <= ALPHA_RESET;
        end
        else
        begin
            kind_reg  <= kind_next;
            alpha_reg <= alpha_next;
        end
    end

    assign busy = 1'b0;

    // stage 0: capture and exponent argument
    logic        s0_valid_reg;
    act_side_t   s0_side_reg, s0_side_next;
    logic [15:0] s0_arg_reg;
    logic        s0_zero_reg;
    logic [16:0] t_abs;
    logic [17:0] earg;

    always_comb
    begin
        t_abs = request.x_value[15] ? (17'd0 - {request.x_value[15], request.x_value})
                                    : {1'b0, request.x_value};
        earg  = (kind_reg == ACT_TANH) ? {t_abs, 1'b0} : {1'b0, t_abs};
        s0_side_next.kind  = kind_reg;
        s0_side_next.mode  = request.mode;
        s0_side_next.neg   = request.x_value[15];
        s0_side_next.pos   = !request.x_value[15] && (request.x_value != 16'sd0);
        s0_side_next.x     = request.x_value;
        s0_side_next.y     = request.y_value;
        s0_side_next.g     = request.grad_in;
        s0_side_next.alpha = alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_side_reg <= s0_side_next;
        s0_arg_reg  <= earg[15:0];
        s0_zero_reg <= |earg[17:16];
    end

    // exponential
    logic        ex_valid;
    act_side_t   ex_side;
    logic [16:0] ex_e;

    act_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_side   (s0_side_reg),
        .in_arg    (s0_arg_reg),
        .in_zero   (s0_zero_reg),
        .out_valid (ex_valid),
        .out_side  (ex_side),
        .out_e     (ex_e)
    );

    // stage p1: divider operands and first product
    logic               p1_valid_reg;
    act_side_t          p1_side_reg;
    logic [27:0]        p1_num_reg, p1_num_next;
    logic [17:0]        p1_den_reg, p1_den_next;
    logic signed [31:0] p1_prod_reg, p1_prod_next;
    logic [16:0]        one_minus_e;
    logic signed [16:0] y_ext, y_comp;

    always_comb
    begin
        one_minus_e = 17'd65536 - ex_e;
        p1_den_next = 18'd65536 + 18'(ex_e);
        if (ex_side.kind == ACT_TANH)
        begin
            p1_num_next = (28'(one_minus_e) << 11) + 28'(p1_den_next >> 1);
        end
        else
        begin
            p1_num_next = 28'd134217728 + 28'(p1_den_next >> 1);
        end
        y_ext  = {ex_side.y[15], ex_side.y};
        y_comp = 17'sd2048 - y_ext;
        case (ex_side.kind)
            ACT_ELU:
            begin
                if (ex_side.mode)
                begin
                    p1_prod_next = $signed(32'(29'(ex_side.alpha) * 29'(ex_e)));
                end
                else
                begin
                    p1_prod_next = $signed(32'(29'(ex_side.alpha) * 29'(one_minus_e)));
                end
            end
            ACT_SIGMOID: p1_prod_next = 32'(y_ext) * 32'(y_comp);
            ACT_TANH:    p1_prod_next = 32'(ex_side.y) * 32'(ex_side.y);
            default:     p1_prod_next = 32'sd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= ex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_side_reg <= ex_side;
        p1_num_reg  <= p1_num_next;
        p1_den_reg  <= p1_den_next;
        p1_prod_reg <= p1_prod_next;
    end

    // stage p2: derivative term and forward elu, relu
    logic               p2_valid_reg;
    act_side_t          p2_side_reg;
    logic [27:0]        p2_num_reg;
    logic [17:0]        p2_den_reg;
    logic signed [31:0] p2_dv_reg, p2_dv_next;
    logic signed [15:0] p2_fwd_reg, p2_fwd_next;
    logic [31:0]        rounded;

    always_comb
    begin
        rounded = (32'(p1_prod_reg) + 32'd32768) >> 16;
        case (p1_side_reg.kind)
            ACT_ELU:     p2_dv_next = $signed(rounded);
            ACT_SIGMOID: p2_dv_next = p1_prod_reg;
            ACT_TANH:    p2_dv_next = 32'sd4194304 - p1_prod_reg;
            default:     p2_dv_next = 32'sd0;
        endcase
        case (p1_side_reg.kind)
            ACT_RELU: p2_fwd_next = p1_side_reg.pos ? p1_side_reg.x : 16'sd0;
            ACT_ELU:  p2_fwd_next = p1_side_reg.neg ? $signed(16'd0 - rounded[15:0])
                                                    : p1_side_reg.x;
            default:  p2_fwd_next = 16'sd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_side_reg <= p1_side_reg;
        p2_num_reg  <= p1_num_reg;
        p2_den_reg  <= p1_den_reg;
        p2_dv_reg   <= p2_dv_next;
        p2_fwd_reg  <= p2_fwd_next;
    end

    // stage p3: gradient product
    logic        p3_valid_reg;
    act_post_t   p3_post_reg, p3_post_next;
    logic [27:0] p3_num_reg;
    logic [17:0] p3_den_reg;

    always_comb
    begin
        p3_post_next.kind = p2_side_reg.kind;
        p3_post_next.mode = p2_side_reg.mode;
        p3_post_next.neg  = p2_side_reg.neg;
        p3_post_next.pos  = p2_side_reg.pos;
        p3_post_next.g    = p2_side_reg.g;
        p3_post_next.fwd  = p2_fwd_reg;
        p3_post_next.prod = 48'(p2_dv_reg) * 48'(p2_side_reg.g);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p3_post_reg <= p3_post_next;
        p3_num_reg  <= p2_num_reg;
        p3_den_reg  <= p2_den_reg;
    end

    // divider
    logic        dv_valid;
    act_post_t   dv_post;
    logic [11:0] dv_quo;

    act_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_valid_reg),
        .in_post   (p3_post_reg),
        .in_num    (p3_num_reg),
        .in_den    (p3_den_reg),
        .out_valid (dv_valid),
        .out_post  (dv_post),
        .out_quo   (dv_quo)
    );

    // output stage: select, round, clip
    logic        done_reg;
    act_out_t    result_reg, result_next;
    logic        mode_out_reg;
    act_kind_t   kind_out_reg;
    logic        pneg;
    logic [47:0] pmag;
    logic [47:0] rs11, rs22, rmag;
    logic [15:0] q16;

    always_comb
    begin
        q16  = {4'd0, dv_quo};
        pneg = dv_post.prod[47];
        pmag = pneg ? (48'd0 - 48'(dv_post.prod)) : 48'(dv_post.prod);
        rs11 = (pmag + 48'd1024) >> 11;
        rs22 = (pmag + 48'd2097152) >> 22;
        rmag = (dv_post.kind == ACT_ELU) ? rs11 : rs22;
        result_next.saturated = 1'b0;
        if (!dv_post.mode)
        begin
            case (dv_post.kind)
                ACT_SIGMOID: result_next.result_value =
                                 dv_post.neg ? $signed(16'd2048 - q16) : $signed(q16);
                ACT_TANH:    result_next.result_value =
                                 dv_post.neg ? $signed(16'd0 - q16) : $signed(q16);
                default:     result_next.result_value = dv_post.fwd;
            endcase
        end
        else if ((dv_post.kind == ACT_RELU) || (dv_post.kind == ACT_ELU && !dv_post.neg))
        begin
            result_next.result_value =
                (dv_post.kind == ACT_RELU && !dv_post.pos) ? 16'sd0 : dv_post.g;
        end
        else if (!pneg && rmag > 48'd32767)
        begin
            result_next.result_value = 16'sd32767;
            result_next.saturated    = 1'b1;
        end
        else if (pneg && rmag > 48'd32768)
        begin
            result_next.result_value = -16'sd32768;
            result_next.saturated    = 1'b1;
        end
        else
        begin
            result_next.result_value = pneg ? $signed(16'd0 - rmag[15:0]) : $signed(rmag[15:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        mode_out_reg <= dv_post.mode;
        kind_out_reg <= dv_post.kind;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##33 done)
        else $error("request did not produce a result at the pipeline latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##33 !done)
        else $error("result produced without a request");

    a_fwd_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && !mode_out_reg |-> !result.saturated)
        else $error("forward result flagged as saturated");

    a_sigmoid_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !mode_out_reg && kind_out_reg == ACT_SIGMOID |->
            result.result_value >= 16'sd0 && result.result_value <= 16'sd2048)
        else $error("forward sigmoid out of range");
`endif

endmodule
